// ===== sv/round_robin_sleep_scheduler_assert.svh =====
`ifndef ROUND_ROBIN_SLEEP_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_SLEEP_SCHEDULER_ASSERT_SVH
// implication check, reset-qualified
`define RRSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication check
`define RRSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/rrss_pkg.sv =====
package rrss_pkg;
  localparam int MaxTasks = 16;
  localparam int SlotW = $clog2(MaxTasks);
  localparam int CntW = SlotW + 1;
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_CREATE = 2'd1;
  localparam logic [1:0] OP_YIELD = 2'd2;
  localparam logic [1:0] OP_SLEEP = 2'd3;
  localparam logic CFG_SLICE = 1'b0;
  localparam logic CFG_TICK = 1'b1;
  localparam logic [1:0] SLOT_FREE = 2'd0;
  localparam logic [1:0] SLOT_READY = 2'd1;
  localparam logic [1:0] SLOT_SLEEP = 2'd2;
  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  task_slot;
    logic [31:0] sleep_ms;
  } in_item_t;
  typedef struct packed {
    logic [3:0] running_slot;
    logic       running_idle;
    logic       switched;
    logic       status;
  } out_item_t;
  typedef struct packed {
    logic       index;
    logic [9:0] data;
  } cfg_item_t;
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [9:0]  divisor;
  } div_req_t;
  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage

// ===== sv/rrss_if.sv =====
interface rrss_in_if import rrss_pkg::*; ();
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rrss_out_if import rrss_pkg::*; ();
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rrss_cfg_if import rrss_pkg::*; ();
  logic valid;
  logic ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rrss_div.sv =====
// ceil division, one quotient bit per cycle
module rrss_div import rrss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [31:0] q_r, q_nxt;
  logic [10:0] rem_r, rem_nxt;
  logic [9:0]  d_r, d_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [10:0] sh;
  logic [31:0] qs;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh = {rem_r[9:0], q_r[31]};
    qs = {q_r[30:0], 1'b0};
    if (req.start) begin
      q_nxt = req.dividend;
      rem_nxt = '0;
      d_nxt = req.divisor;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, d_r}) begin
        rem_nxt = sh - {1'b0, d_r};
        q_nxt = qs | 32'd1;
      end else begin
        rem_nxt = sh;
        q_nxt = qs;
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    d_r <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quotient = q_r + {31'd0, (rem_r != '0)};
endmodule

// ===== sv/round_robin_sleep_scheduler.sv =====
// Hardware round-robin scheduler for 16 task slots plus an idle task. One op is taken at
// a time and returns one result; the next item is taken once that result has gone.
// Create and a rejected sleep pass from execution straight to the result; yield also
// dispatches first; sleep waits for the bit-serial divider that turns milliseconds into
// ticks; tick walks the sleep list entry by entry before dispatch. Configuration
// writes are taken at any time but belong between ops.
module round_robin_sleep_scheduler import rrss_pkg::*; (
  input logic clk,
  input logic rst_n,
  rrss_in_if.sink    in_ch,
  rrss_out_if.source out_ch,
  rrss_cfg_if.sink   cfg_ch
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_DIVW = 7'b0000100,
    S_WALK = 7'b0001000,
    S_DISP = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_DIVS = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [7:0]  slice_len_r;
  logic [9:0]  tick_ms_r;
  logic [SlotW-1:0] rq_r [MaxTasks];
  logic [SlotW-1:0] sq_r [MaxTasks];
  logic [31:0] srem_r [MaxTasks];
  logic [7:0]  slice_r [MaxTasks+1];
  logic [1:0]  sst_r [MaxTasks];
  logic [SlotW-1:0] head_r;
  logic [CntW-1:0]  rcnt_r, scnt_r, walk_r, kept_r;
  logic [SlotW-1:0] cur_r;
  logic idle_r;
  in_item_t  op_r;
  out_item_t res_r;
  logic ovalid_r;
  div_req_t dreq;
  div_rsp_t drsp;
  logic [31:0] m_val;
  logic [9:0]  tp;
  logic [SlotW-1:0] ws, nslot;
  logic [31:0] wv;
  logic [SlotW:0] six;
  logic [7:0]  sv;
  logic        nidle, sw, rej;

  rrss_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign tp = (tick_ms_r == '0) ? 10'd1 : tick_ms_r;
  assign m_val = (op_r.sleep_ms < {22'd0, tp}) ? {22'd0, tp} : op_r.sleep_ms;
  assign dreq.start = (state_r == S_DIVS);
  assign dreq.dividend = m_val;
  assign dreq.divisor = tp;
  assign ws = sq_r[walk_r[SlotW-1:0]];
  assign wv = srem_r[ws] - 32'd1;
  assign six = idle_r ? CntW'(MaxTasks) : {1'b0, cur_r};
  assign sv = slice_r[six] - 8'd1;
  assign nidle = (rcnt_r == '0);
  assign nslot = nidle ? '0 : rq_r[head_r];
  assign sw = (idle_r != nidle) || (!nidle && cur_r != nslot);
  assign rej = ((op_r.opcode == OP_CREATE) && (sst_r[op_r.task_slot] != SLOT_FREE))
               || ((op_r.opcode == OP_SLEEP) && idle_r);

  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_nxt = S_EXEC;
      S_EXEC: begin
        unique case (op_r.opcode)
          OP_TICK:   state_nxt = S_WALK;
          OP_CREATE: state_nxt = S_OUT;
          OP_YIELD:  state_nxt = S_DISP;
          OP_SLEEP:  state_nxt = idle_r ? S_OUT : S_DIVS;
          default:   state_nxt = S_OUT;
        endcase
      end
      S_DIVS: state_nxt = S_DIVW;
      S_DIVW: if (drsp.done) state_nxt = S_DISP;
      S_WALK: if (walk_r >= scnt_r) state_nxt = S_DISP;
      S_DISP: state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slice_len_r <= 8'd10;
      tick_ms_r <= 10'd10;
      for (int i = 0; i < MaxTasks; i++) sst_r[i] <= SLOT_FREE;
      for (int i = 0; i <= MaxTasks; i++) slice_r[i] <= 8'd10;
      head_r <= '0;
      rcnt_r <= '0;
      scnt_r <= '0;
      cur_r <= '0;
      idle_r <= 1'b1;
      ovalid_r <= 1'b0;
      walk_r <= '0;
      kept_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        if (cfg_ch.data.index == CFG_SLICE) slice_len_r <= cfg_ch.data.data[7:0];
        else tick_ms_r <= cfg_ch.data.data;
      end
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) op_r <= in_ch.data;
        S_EXEC: begin
          res_r <= '{running_slot: 4'd0, running_idle: 1'b0, switched: 1'b0, status: rej};
          walk_r <= '0;
          kept_r <= '0;
          unique case (op_r.opcode)
            OP_TICK: begin
              if (sv == '0) begin
                slice_r[six] <= slice_len_r;
                if (!idle_r && rcnt_r != '0) begin
                  rq_r[head_r + rcnt_r[SlotW-1:0]] <= cur_r;
                  head_r <= head_r + 1'b1;
                end
              end else begin
                slice_r[six] <= sv;
              end
            end
            OP_CREATE: begin
              if (sst_r[op_r.task_slot] == SLOT_FREE) begin
                sst_r[op_r.task_slot] <= SLOT_READY;
                slice_r[{1'b0, op_r.task_slot}] <= slice_len_r;
                rq_r[head_r + rcnt_r[SlotW-1:0]] <= op_r.task_slot;
                rcnt_r <= rcnt_r + 1'b1;
              end
            end
            OP_YIELD: begin
              if (!idle_r && rcnt_r != '0) begin
                rq_r[head_r + rcnt_r[SlotW-1:0]] <= cur_r;
                head_r <= head_r + 1'b1;
              end
            end
            OP_SLEEP: begin
              if (!idle_r) begin
                if (rcnt_r != '0) begin
                  head_r <= head_r + 1'b1;
                  rcnt_r <= rcnt_r - 1'b1;
                end
                sst_r[cur_r] <= SLOT_SLEEP;
                if (scnt_r < CntW'(MaxTasks)) begin
                  sq_r[scnt_r[SlotW-1:0]] <= cur_r;
                  scnt_r <= scnt_r + 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        S_DIVW: if (drsp.done) srem_r[cur_r] <= drsp.quotient;
        S_WALK: begin
          if (walk_r < scnt_r) begin
            srem_r[ws] <= wv;
            walk_r <= walk_r + 1'b1;
            if (wv == '0) begin
              sst_r[ws] <= SLOT_READY;
              if (rcnt_r < CntW'(MaxTasks)) begin
                rq_r[head_r + rcnt_r[SlotW-1:0]] <= ws;
                rcnt_r <= rcnt_r + 1'b1;
              end
            end else begin
              sq_r[kept_r[SlotW-1:0]] <= ws;
              kept_r <= kept_r + 1'b1;
            end
          end else begin
            scnt_r <= kept_r;
          end
        end
        S_DISP: begin
          res_r.switched <= sw;
          idle_r <= nidle;
          cur_r <= nslot;
        end
        S_OUT: begin
          res_r <= '{running_slot: idle_r ? 4'd0 : cur_r, running_idle: idle_r,
                     switched: res_r.switched, status: res_r.status};
          ovalid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== sv/rrss_checker.sv =====
`include "round_robin_sleep_scheduler_assert.svh"
module rrss_checker import rrss_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_item_t out_data
);
  `RRSS_ASSERT_IMP(a_idle_slot0, out_valid && out_data.running_idle, out_data.running_slot == 4'd0)
  `RRSS_ASSERT_IMP(a_no_accept_pending, out_valid, !in_ready)
  `RRSS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `RRSS_ASSERT_IMP(a_reject_no_switch, out_valid && out_data.status, !out_data.switched)
  `RRSS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind round_robin_sleep_scheduler rrss_checker u_rrss_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
